// File: hdl/cup_pkg.sv
// Package: shared types and constants for the clause unit propagation block.
package cup_pkg;

	localparam int VAR_W   = 10;
	localparam int WORD_W  = 34;
	localparam int ALIVE_B = 33;

	localparam logic [2:0] KIND_CLEAR = 3'd0;
	localparam logic [2:0] KIND_LOAD  = 3'd1;
	localparam logic [2:0] KIND_FIX   = 3'd2;
	localparam logic [2:0] KIND_PROP  = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CONFLICT = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] VS_FREE  = 2'd0;
	localparam logic [1:0] VS_FALSE = 2'd1;
	localparam logic [1:0] VS_TRUE  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_EMIT,
		S_RD_WAIT,
		S_FIX_RD,
		S_FIX_WR,
		S_F_RD,
		S_F_CHK,
		S_P_RD,
		S_P_CL,
		S_P_VRD,
		S_P_VEV,
		S_P_DEC
	} state_t;

	function automatic logic [VAR_W-1:0] lit_var(input logic [WORD_W-1:0] w,
		input logic [1:0] p);
		logic [VAR_W-1:0] r;
		unique case (p)
			2'd0: r = w[9:0];
			2'd1: r = w[20:11];
			default: r = w[31:22];
		endcase
		return r;
	endfunction

	function automatic logic lit_sign(input logic [WORD_W-1:0] w, input logic [1:0] p);
		logic r;
		unique case (p)
			2'd0: r = w[10];
			2'd1: r = w[21];
			default: r = w[32];
		endcase
		return r;
	endfunction

endpackage

// File: hdl/clause_unit_propagation.sv
// Top level: 3-literal clause table with load, clear, fix, unit propagation and variable read.
//
// channel | direction | handshake         | word
// in      | input     | in_valid/in_stall | kind, var_a..c, sign_a..c, fix_value
// out     | output    | out_valid/out_stall | status, var_state, assigned_count, active_count
//
// Clear sweeps the variable memory before it answers. Fix writes the variable and then
// scans every loaded clause; a variable out of range skips both. Propagate makes passes
// over the loaded clauses until a pass forces no variable or a conflict is found; each
// memory has a single read port.
// After reset the variable memory is swept; no word is accepted meanwhile. One word
// at a time; out holds its word while out_stall.
module clause_unit_propagation #(
	parameter int VAR_CAPACITY    = 1024,
	parameter int CLAUSE_CAPACITY = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [9:0]  var_a,
	input  logic [9:0]  var_b,
	input  logic [9:0]  var_c,
	input  logic        sign_a,
	input  logic        sign_b,
	input  logic        sign_c,
	input  logic        fix_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [1:0]  var_state,
	output logic [10:0] assigned_count,
	output logic [12:0] active_count
);

	localparam int VW = $clog2(VAR_CAPACITY);
	localparam int AW = $clog2(CLAUSE_CAPACITY);
	localparam int CW = $clog2(CLAUSE_CAPACITY + 1);
	localparam int WW = cup_pkg::WORD_W;

	cup_pkg::state_t state_q, state_d;
	logic [CW-1:0] ci_q, ci_d, total_q, total_d;
	logic [VW-1:0] vcnt_q, vcnt_d;
	logic [1:0]    lit_q, lit_d, free_q, free_d;
	logic [9:0]    va_q, va_d, fvar_q, fvar_d;
	logic          fix_q, fix_d, sat_q, sat_d, fsign_q, fsign_d, forced_q, forced_d;
	logic          clr_emit_q, clr_emit_d;
	logic [WW-1:0] clause_q, clause_d;
	logic [10:0]   asg_q, asg_d;
	logic [12:0]   alive_q, alive_d;
	logic [1:0]    rstat_q, rstat_d, rvs_q, rvs_d;
	logic          ov_q, ov_d;
	logic [1:0]    ost_q, ost_d, ovs_q, ovs_d;
	logic [10:0]   oasg_q, oasg_d;
	logic [12:0]   oalive_q, oalive_d;

	logic          cm_we;
	logic [AW-1:0] cm_waddr, cm_raddr;
	logic [WW-1:0] cm_wdata, cm_rdata;
	logic          vm_we;
	logic [VW-1:0] vm_waddr, vm_raddr;
	logic [1:0]    vm_wdata, vm_rdata;

	logic [9:0]    cur_var;
	logic          cur_sign, cur_inr, va_inr, hit;

	cup_ram #(.WIDTH(WW), .DEPTH(CLAUSE_CAPACITY)) u_clause_ram (
		.clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
		.raddr(cm_raddr), .rdata(cm_rdata)
	);

	cup_ram #(.WIDTH(2), .DEPTH(VAR_CAPACITY)) u_var_ram (
		.clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
		.raddr(vm_raddr), .rdata(vm_rdata)
	);

	assign in_stall       = (state_q != cup_pkg::S_IDLE);
	assign out_valid      = ov_q;
	assign status         = ost_q;
	assign var_state      = ovs_q;
	assign assigned_count = oasg_q;
	assign active_count   = oalive_q;

	always_comb begin
		cur_var  = cup_pkg::lit_var(clause_q, lit_q);
		cur_sign = cup_pkg::lit_sign(clause_q, lit_q);
		cur_inr  = ({22'd0, cur_var} < 32'(VAR_CAPACITY));
		va_inr   = ({22'd0, va_q} < 32'(VAR_CAPACITY));
		hit = 1'b0;
		for (int p = 0; p < 3; p++) begin
			if (cup_pkg::lit_var(cm_rdata, 2'(p)) == va_q &&
				cup_pkg::lit_sign(cm_rdata, 2'(p)) == fix_q) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		ci_d       = ci_q;
		total_d    = total_q;
		vcnt_d     = vcnt_q;
		lit_d      = lit_q;
		free_d     = free_q;
		va_d       = va_q;
		fvar_d     = fvar_q;
		fix_d      = fix_q;
		sat_d      = sat_q;
		fsign_d    = fsign_q;
		forced_d   = forced_q;
		clr_emit_d = clr_emit_q;
		clause_d   = clause_q;
		asg_d      = asg_q;
		alive_d    = alive_q;
		rstat_d    = rstat_q;
		rvs_d      = rvs_q;
		ov_d       = ov_q && out_stall;
		ost_d      = ost_q;
		ovs_d      = ovs_q;
		oasg_d     = oasg_q;
		oalive_d   = oalive_q;
		cm_we      = 1'b0;
		cm_waddr   = ci_q[AW-1:0];
		cm_wdata   = clause_q;
		cm_raddr   = ci_q[AW-1:0];
		vm_we      = 1'b0;
		vm_waddr   = VW'(va_q);
		vm_wdata   = cup_pkg::VS_FREE;
		vm_raddr   = VW'(va_q);

		unique case (state_q)
			cup_pkg::S_IDLE: begin
				vm_raddr = VW'(var_a);
				if (in_valid) begin
					va_d    = var_a;
					fix_d   = fix_value;
					rstat_d = cup_pkg::ST_OK;
					rvs_d   = cup_pkg::VS_FREE;
					state_d = cup_pkg::S_EMIT;
					unique case (kind)
						cup_pkg::KIND_CLEAR: begin
							total_d    = '0;
							asg_d      = '0;
							alive_d    = '0;
							vcnt_d     = '0;
							clr_emit_d = 1'b1;
							state_d    = cup_pkg::S_CLR;
						end
						cup_pkg::KIND_LOAD: begin
							if (total_q == CW'(CLAUSE_CAPACITY)) begin
								rstat_d = cup_pkg::ST_FULL;
							end else begin
								cm_we    = 1'b1;
								cm_waddr = total_q[AW-1:0];
								cm_wdata = {1'b1, sign_c, var_c, sign_b, var_b, sign_a, var_a};
								total_d  = total_q + 1'b1;
								alive_d  = alive_q + 1'b1;
							end
						end
						cup_pkg::KIND_FIX: begin
							state_d = cup_pkg::S_FIX_RD;
						end
						cup_pkg::KIND_PROP: begin
							ci_d     = '0;
							forced_d = 1'b0;
							state_d  = cup_pkg::S_P_RD;
						end
						cup_pkg::KIND_READ: begin
							state_d = cup_pkg::S_RD_WAIT;
						end
						default: begin
						end
					endcase
				end
			end
			cup_pkg::S_CLR: begin
				vm_we    = 1'b1;
				vm_waddr = vcnt_q;
				vm_wdata = cup_pkg::VS_FREE;
				vcnt_d   = vcnt_q + 1'b1;
				if (vcnt_q == VW'(VAR_CAPACITY - 1)) begin
					state_d = clr_emit_q ? cup_pkg::S_EMIT : cup_pkg::S_IDLE;
				end
			end
			cup_pkg::S_EMIT: begin
				if (!ov_q || !out_stall) begin
					ov_d     = 1'b1;
					ost_d    = rstat_q;
					ovs_d    = rvs_q;
					oasg_d   = asg_q;
					oalive_d = alive_q;
					state_d  = cup_pkg::S_IDLE;
				end
			end
			cup_pkg::S_RD_WAIT: begin
				rvs_d   = va_inr ? vm_rdata : cup_pkg::VS_FREE;
				state_d = cup_pkg::S_EMIT;
			end
			cup_pkg::S_FIX_RD: begin
				state_d = va_inr ? cup_pkg::S_FIX_WR : cup_pkg::S_EMIT;
			end
			cup_pkg::S_FIX_WR: begin
				vm_we    = 1'b1;
				vm_wdata = fix_q ? cup_pkg::VS_TRUE : cup_pkg::VS_FALSE;
				if (vm_rdata == cup_pkg::VS_FREE) begin
					asg_d = asg_q + 1'b1;
				end
				ci_d    = '0;
				state_d = cup_pkg::S_F_RD;
			end
			cup_pkg::S_F_RD: begin
				state_d = (ci_q == total_q) ? cup_pkg::S_EMIT : cup_pkg::S_F_CHK;
			end
			cup_pkg::S_F_CHK: begin
				if (cm_rdata[cup_pkg::ALIVE_B] && hit) begin
					cm_we    = 1'b1;
					cm_wdata = {1'b0, cm_rdata[WW-2:0]};
					alive_d  = alive_q - 1'b1;
				end
				ci_d     = ci_q + 1'b1;
				cm_raddr = ci_d[AW-1:0];
				state_d  = cup_pkg::S_F_RD;
			end
			cup_pkg::S_P_RD: begin
				if (ci_q == total_q) begin
					if (forced_q) begin
						ci_d     = '0;
						forced_d = 1'b0;
					end else begin
						state_d = cup_pkg::S_EMIT;
					end
				end else begin
					state_d = cup_pkg::S_P_CL;
				end
			end
			cup_pkg::S_P_CL: begin
				clause_d = cm_rdata;
				lit_d    = '0;
				sat_d    = 1'b0;
				free_d   = '0;
				if (cm_rdata[cup_pkg::ALIVE_B]) begin
					state_d = cup_pkg::S_P_VRD;
				end else begin
					ci_d    = ci_q + 1'b1;
					state_d = cup_pkg::S_P_RD;
				end
			end
			cup_pkg::S_P_VRD: begin
				vm_raddr = VW'(cur_var);
				state_d  = cup_pkg::S_P_VEV;
			end
			cup_pkg::S_P_VEV: begin
				if (cur_inr) begin
					if (vm_rdata == cup_pkg::VS_FREE) begin
						if (free_q != 2'd2) begin
							free_d = free_q + 1'b1;
						end
						fvar_d  = cur_var;
						fsign_d = cur_sign;
					end else if ((vm_rdata == cup_pkg::VS_TRUE) == cur_sign) begin
						sat_d = 1'b1;
					end
				end
				if (lit_q == 2'd2) begin
					state_d = cup_pkg::S_P_DEC;
				end else begin
					lit_d   = lit_q + 1'b1;
					state_d = cup_pkg::S_P_VRD;
				end
			end
			cup_pkg::S_P_DEC: begin
				ci_d    = ci_q + 1'b1;
				state_d = cup_pkg::S_P_RD;
				if (sat_q) begin
					cm_we    = 1'b1;
					cm_wdata = {1'b0, clause_q[WW-2:0]};
					alive_d  = alive_q - 1'b1;
				end else if (free_q == 2'd0) begin
					rstat_d = cup_pkg::ST_CONFLICT;
					state_d = cup_pkg::S_EMIT;
				end else if (free_q == 2'd1) begin
					vm_we    = 1'b1;
					vm_waddr = VW'(fvar_q);
					vm_wdata = fsign_q ? cup_pkg::VS_TRUE : cup_pkg::VS_FALSE;
					asg_d    = asg_q + 1'b1;
					forced_d = 1'b1;
				end
				if (state_d == cup_pkg::S_P_RD) begin
					cm_raddr = ci_d[AW-1:0];
				end
			end
			default: begin
				state_d = cup_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cup_pkg::S_CLR;
			vcnt_q     <= '0;
			clr_emit_q <= 1'b0;
			total_q    <= '0;
			asg_q      <= '0;
			alive_q    <= '0;
			ov_q       <= 1'b0;
			ci_q       <= '0;
			forced_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			vcnt_q     <= vcnt_d;
			clr_emit_q <= clr_emit_d;
			total_q    <= total_d;
			asg_q      <= asg_d;
			alive_q    <= alive_d;
			ov_q       <= ov_d;
			ci_q       <= ci_d;
			forced_q   <= forced_d;
		end
	end

	always_ff @(posedge clk) begin
		lit_q    <= lit_d;
		free_q   <= free_d;
		va_q     <= va_d;
		fvar_q   <= fvar_d;
		fix_q    <= fix_d;
		sat_q    <= sat_d;
		fsign_q  <= fsign_d;
		clause_q <= clause_d;
		rstat_q  <= rstat_d;
		rvs_q    <= rvs_d;
		ost_q    <= ost_d;
		ovs_q    <= ovs_d;
		oasg_q   <= oasg_d;
		oalive_q <= oalive_d;
	end

endmodule

// File: hdl/cup_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cup_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: tb/clause_unit_propagation_test.sv
// Testbench for the clause unit propagation block: directed and random words checked against a scoreboard.
`timescale 1ns / 1ps

module clause_unit_propagation_test;

	localparam int NVAR = 1024;
	localparam int NCLS = 4096;
	localparam int WATCHDOG = 200000;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  var_state;
		logic [10:0] assigned_count;
		logic [12:0] active_count;
	} verdict_t;

	class propagation_board;
		logic [32:0] lits[NCLS];
		bit          alive[NCLS];
		logic [1:0]  assign_of[NVAR];
		int          n_loaded, n_assigned, n_alive;
		verdict_t    pending[$];
		int          errors;

		function void wipe();
			for (int i = 0; i < NCLS; i++) alive[i] = 0;
			for (int i = 0; i < NVAR; i++) assign_of[i] = cup_pkg::VS_FREE;
			n_loaded = 0;
			n_assigned = 0;
			n_alive = 0;
		endfunction

		// 0 false, 1 true, 2 free
		function int lit_value(logic [9:0] v, logic s);
			if (v >= NVAR) return 0;
			if (assign_of[v] == cup_pkg::VS_FREE) return 2;
			return ((assign_of[v] == cup_pkg::VS_TRUE) == s) ? 1 : 0;
		endfunction

		function void set_var(logic [9:0] v, logic val);
			if (v >= NVAR) return;
			if (assign_of[v] == cup_pkg::VS_FREE) n_assigned++;
			assign_of[v] = val ? cup_pkg::VS_TRUE : cup_pkg::VS_FALSE;
		endfunction

		function void retire(int ci);
			if (alive[ci]) begin
				alive[ci] = 0;
				n_alive--;
			end
		endfunction

		function logic [1:0] unit_propagate();
			bit again;
			int nfree, e;
			bit sat;
			logic [9:0] fv, v;
			logic fs, s;
			again = 1;
			while (again) begin
				again = 0;
				for (int ci = 0; ci < n_loaded; ci++) begin
					if (!alive[ci]) continue;
					nfree = 0;
					sat = 0;
					fv = 0;
					fs = 0;
					for (int p = 0; p < 3; p++) begin
						v = lits[ci][11*p +: 10];
						s = lits[ci][11*p + 10];
						e = lit_value(v, s);
						if (e == 1) sat = 1;
						else if (e == 2) begin
							nfree++;
							fv = v;
							fs = s;
						end
					end
					if (sat) begin
						retire(ci);
						continue;
					end
					if (nfree == 0) return cup_pkg::ST_CONFLICT;
					if (nfree == 1) begin
						set_var(fv, fs);
						again = 1;
					end
				end
			end
			return cup_pkg::ST_OK;
		endfunction

		function void note_word(logic [2:0] k, logic [9:0] va, logic [9:0] vb,
			logic [9:0] vc, logic sa, logic sb, logic sc, logic fx);
			verdict_t r;
			r = '0;
			r.status = cup_pkg::ST_OK;
			r.var_state = cup_pkg::VS_FREE;
			case (k)
				cup_pkg::KIND_CLEAR: wipe();
				cup_pkg::KIND_LOAD: begin
					if (n_loaded >= NCLS) r.status = cup_pkg::ST_FULL;
					else begin
						lits[n_loaded] = {sc, vc, sb, vb, sa, va};
						alive[n_loaded] = 1;
						n_loaded++;
						n_alive++;
					end
				end
				cup_pkg::KIND_FIX: begin
					if (va < NVAR) begin
						set_var(va, fx);
						for (int ci = 0; ci < n_loaded; ci++)
							if (alive[ci])
								for (int p = 0; p < 3; p++)
									if (lits[ci][11*p +: 10] == va &&
										lits[ci][11*p + 10] == fx) begin
										retire(ci);
										break;
									end
					end
				end
				cup_pkg::KIND_PROP: r.status = unit_propagate();
				cup_pkg::KIND_READ:
					r.var_state = (va < NVAR) ? assign_of[va] : cup_pkg::VS_FREE;
				default: ;
			endcase
			r.assigned_count = n_assigned[10:0];
			r.active_count = n_alive[12:0];
			pending.push_back(r);
		endfunction

		function void check_word(verdict_t got);
			verdict_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %p", $time, got);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (got.status !== x.status) begin
				$display("%0t: status exp %0d got %0d", $time, x.status, got.status);
				errors++;
			end
			if (got.var_state !== x.var_state) begin
				$display("%0t: var_state exp %0d got %0d", $time, x.var_state, got.var_state);
				errors++;
			end
			if (got.assigned_count !== x.assigned_count) begin
				$display("%0t: assigned_count exp %0d got %0d", $time,
					x.assigned_count, got.assigned_count);
				errors++;
			end
			if (got.active_count !== x.active_count) begin
				$display("%0t: active_count exp %0d got %0d", $time,
					x.active_count, got.active_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] kind = 0;
	logic [9:0] var_a = 0, var_b = 0, var_c = 0;
	logic sign_a = 0, sign_b = 0, sign_c = 0, fix_value = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status, var_state;
	logic [10:0] assigned_count;
	logic [12:0] active_count;

	propagation_board board = new();
	bit calm = 0;
	int idle_cycles = 0;
	int n_sent = 0, n_got = 0, n_conflicts = 0;

	always #5 clk = ~clk;

	clause_unit_propagation dut (.*);

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				board.check_word({status, var_state, assigned_count, active_count});
				n_got++;
				if (status == cup_pkg::ST_CONFLICT) n_conflicts++;
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else if (arst_n) idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("[clause_unit_propagation] ERROR");
			$finish;
		end
	end

	task automatic send(logic [2:0] k, logic [9:0] va, logic [9:0] vb, logic [9:0] vc,
		logic sa, logic sb, logic sc, logic fx);
		while (!calm && $urandom_range(99) < 22) begin
			in_valid <= 0;
			@(posedge clk);
		end
		kind <= k;
		var_a <= va;
		var_b <= vb;
		var_c <= vc;
		sign_a <= sa;
		sign_b <= sb;
		sign_c <= sc;
		fix_value <= fx;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		board.note_word(k, va, vb, vc, sa, sb, sc, fx);
		n_sent++;
	endtask

	function automatic logic [9:0] pick_var();
		return ($urandom_range(99) < 8) ? 10'($urandom) : 10'($urandom_range(11));
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int r;
		board.errors = 0;
		board.wipe();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(cup_pkg::KIND_LOAD, 0, 1, 2, 1, 1, 1, 0);
		send(cup_pkg::KIND_LOAD, 0, 1, 1023, 0, 0, 1, 0);
		send(cup_pkg::KIND_LOAD, 3, 3, 3, 1, 0, 1, 0);
		send(cup_pkg::KIND_LOAD, 1023, 1023, 1023, 0, 0, 0, 0);
		send(cup_pkg::KIND_FIX, 0, 0, 0, 0, 0, 0, 1);
		send(cup_pkg::KIND_FIX, 0, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_FIX, 1023, 0, 0, 0, 0, 0, 1);
		send(cup_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_READ, 1023, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_READ, 5, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_PROP, 0, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_READ, 1, 0, 0, 0, 0, 0, 0);
		send(3'd5, 10'h3ff, 10'h3ff, 10'h3ff, 1, 1, 1, 1);
		send(3'd6, 0, 0, 0, 0, 0, 0, 0);
		send(3'd7, 0, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send(cup_pkg::KIND_LOAD, 4, 4, 4, 1, 1, 1, 0);
		send(cup_pkg::KIND_LOAD, 4, 4, 4, 0, 0, 0, 0);
		send(cup_pkg::KIND_PROP, 0, 0, 0, 0, 0, 0, 0);
		drain();
		send(cup_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		// random sessions: small formulas over few variables
		for (int sess = 0; sess < 10; sess++) begin
			if (sess == 5) calm = 1;
			if (sess == 8) calm = 0;
			if (sess == 3) drain();
			for (int j = 0; j < 10; j++) begin
				r = $urandom_range(99);
				if (r < 45)
					send(cup_pkg::KIND_LOAD, pick_var(), pick_var(), pick_var(),
						1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
				else if (r < 65)
					send(cup_pkg::KIND_FIX, pick_var(), 10'($urandom), 10'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
				else if (r < 82)
					send(cup_pkg::KIND_PROP, 10'($urandom), 10'($urandom), 10'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
				else if (r < 96)
					send(cup_pkg::KIND_READ, pick_var(), 10'($urandom), 10'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
				else
					send(3'($urandom_range(7, 5)), 10'($urandom), 10'($urandom),
						10'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
						1'($urandom));
			end
			send(cup_pkg::KIND_PROP, 0, 0, 0, 0, 0, 0, 0);
			send(cup_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		end
		drain();
		repeat (50) @(posedge clk);
		$display("Sent %0d words, checked %0d results, %0d conflicts seen.",
			n_sent, n_got, n_conflicts);
		$display("Covered out-of-range variables, refix, clear, unknown kinds, stalls.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[clause_unit_propagation] OK");
		else
			$display("[clause_unit_propagation] ERROR");
		$finish;
	end
endmodule

// File: clause_unit_propagation.f
hdl/cup_pkg.sv
hdl/cup_ram.sv
hdl/clause_unit_propagation.sv
tb/clause_unit_propagation_test.sv
